>>> design/e2q_pkg.sv
// shared constants and types for the euler to quaternion converter
`timescale 1ns / 1ps
package e2q_pkg;

  // internal fixed point: 30 fraction bits
  localparam int unsigned FRAC = 30;
  localparam int unsigned XW   = 33;  // sine / cosine width
  localparam int unsigned HW   = 34;  // residual angle width

  localparam int unsigned ANGLE_BITS_DEF   = 16;
  localparam int unsigned OUT_BITS_DEF     = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;
  localparam logic signed [HW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [HW-1:0] PI_Q30      = 34'sd3373259426;

  typedef logic signed [XW-1:0] trig_t;
  typedef logic signed [HW-1:0] ang_t;

  // arctangent of 2^-k, truncated to 30 fraction bits
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

endpackage

>>> design/euler_to_quaternion.sv
// euler zyx angles to unit quaternion, streaming pipeline
//
//  channel   dir  tdata fields (low bit up)                  beat
//  s_axis    in   roll_angle, pitch_angle, yaw_angle         one angle triple
//  m_axis    out  quat_w, quat_x, quat_y, quat_z             one quaternion
//
// one beat per cycle sustained while m_axis is not stalled; the pipeline is the
// one-step-per-stage cordic plus two multiply stages, a round and a clamp stage
// rst_ni clears only the stage valid bits
// a stall on m_axis freezes every stage at once; s_tready follows m_tready
// when the last stage is full, so nothing is dropped or repeated
`timescale 1ns / 1ps
module euler_to_quaternion #(
  parameter int unsigned ANGLE_BITS   = e2q_pkg::ANGLE_BITS_DEF,
  parameter int unsigned OUT_BITS     = e2q_pkg::OUT_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF,
  localparam int unsigned IW = ((3 * ANGLE_BITS + 7) / 8) * 8,
  localparam int unsigned OW = ((4 * OUT_BITS + 7) / 8) * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [IW-1:0] s_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [OW-1:0] m_axis_tdata    // quat_w, quat_x, quat_y, quat_z
);
  import e2q_pkg::*;

  localparam int unsigned NV  = CORDIC_STEPS + 6;
  localparam int unsigned PW  = 2 * XW;
  localparam int unsigned SW  = PW + 1;
  localparam int unsigned RSH = 62 - OUT_BITS;
  localparam int unsigned VW  = OUT_BITS + 2;
  localparam logic signed [PW-1:0] HALF_Q30 = PW'(64'd1 << (FRAC - 1));
  localparam logic signed [SW-1:0] RND      = SW'(64'd1 << (RSH - 1));
  localparam logic signed [VW-1:0] LIM      = VW'(64'd1 << (OUT_BITS - 2));

  logic [NV-1:0] vld_q;
  logic          en;

  trig_t sr, cr, sp, cp, sy, cy;

  // whole pipeline advances unless the last beat is stuck
  assign en            = !vld_q[NV-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], s_axis_tvalid};
    end
  end

  // sine and cosine of the three half angles
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk_i(clk_i), .en_i(en), .angle_i(s_axis_tdata[ANGLE_BITS-1:0]),
    .sin_o(sr), .cos_o(cr));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk_i(clk_i), .en_i(en), .angle_i(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
    .sin_o(sp), .cos_o(cp));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
    .clk_i(clk_i), .en_i(en), .angle_i(s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]),
    .sin_o(sy), .cos_o(cy));

  // yaw-roll pair products, rounded back to 30 fraction bits
  logic signed [PW-1:0] cycr_p, sysr_p, cysr_p, sycr_p;
  trig_t cycr_q, sysr_q, cysr_q, sycr_q, sp_q, cp_q;

  assign cycr_p = (PW'(cy) * PW'(cr) + HALF_Q30) >>> FRAC;
  assign sysr_p = (PW'(sy) * PW'(sr) + HALF_Q30) >>> FRAC;
  assign cysr_p = (PW'(cy) * PW'(sr) + HALF_Q30) >>> FRAC;
  assign sycr_p = (PW'(sy) * PW'(cr) + HALF_Q30) >>> FRAC;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cycr_q <= cycr_p[XW-1:0];
      sysr_q <= sysr_p[XW-1:0];
      cysr_q <= cysr_p[XW-1:0];
      sycr_q <= sycr_p[XW-1:0];
      sp_q   <= sp;
      cp_q   <= cp;
    end
  end

  // triple-product sums at 60 fraction bits
  logic signed [SW-1:0] w_sum_q, x_sum_q, y_sum_q, z_sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_sum_q <= SW'(PW'(cycr_q) * PW'(cp_q)) + SW'(PW'(sysr_q) * PW'(sp_q));
      x_sum_q <= SW'(PW'(cysr_q) * PW'(cp_q)) - SW'(PW'(sycr_q) * PW'(sp_q));
      y_sum_q <= SW'(PW'(cycr_q) * PW'(sp_q)) + SW'(PW'(sysr_q) * PW'(cp_q));
      z_sum_q <= SW'(PW'(sycr_q) * PW'(cp_q)) - SW'(PW'(cysr_q) * PW'(sp_q));
    end
  end

  // round half up to the output fraction
  logic signed [SW-1:0] w_r, x_r, y_r, z_r;
  logic signed [VW-1:0] w_v_q, x_v_q, y_v_q, z_v_q;

  assign w_r = (w_sum_q + RND) >>> RSH;
  assign x_r = (x_sum_q + RND) >>> RSH;
  assign y_r = (y_sum_q + RND) >>> RSH;
  assign z_r = (z_sum_q + RND) >>> RSH;

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_v_q <= w_r[VW-1:0];
      x_v_q <= x_r[VW-1:0];
      y_v_q <= y_r[VW-1:0];
      z_v_q <= z_r[VW-1:0];
    end
  end

  // clamp to plus or minus one
  function automatic logic [OUT_BITS-1:0] clamp(logic signed [VW-1:0] v);
    logic signed [VW-1:0] c;
    c = v;
    if (v > LIM) c = LIM;
    if (v < -LIM) c = -LIM;
    return c[OUT_BITS-1:0];
  endfunction

  logic [OUT_BITS-1:0] qw_q, qx_q, qy_q, qz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      qw_q <= clamp(w_v_q);
      qx_q <= clamp(x_v_q);
      qy_q <= clamp(y_v_q);
      qz_q <= clamp(z_v_q);
    end
  end

  assign m_axis_tdata = OW'({qz_q, qy_q, qx_q, qw_q});

`ifndef SYNTH
  // a stuck output beat holds back the input side
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // delivered w and z components never exceed unit magnitude
  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(qw_q) <= $signed(LIM[OUT_BITS-1:0]))
                   && ($signed(qw_q) >= -$signed(LIM[OUT_BITS-1:0])))
    else $error("quat_w out of range");

  a_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(qz_q) <= $signed(LIM[OUT_BITS-1:0]))
                   && ($signed(qz_q) >= -$signed(LIM[OUT_BITS-1:0])))
    else $error("quat_z out of range");

  // output valid only appears after a pipeline advance
  a_rise_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(en))
    else $error("output valid rose without advance");
`endif

endmodule

>>> design/e2q_cordic.sv
// pipelined half-angle sine and cosine, one cordic step per stage
`timescale 1ns / 1ps
module e2q_cordic #(
  parameter int unsigned ANGLE_BITS   = e2q_pkg::ANGLE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output e2q_pkg::trig_t        sin_o,
  output e2q_pkg::trig_t        cos_o
);
  import e2q_pkg::*;

  localparam int unsigned SH = 33 - ANGLE_BITS;

  trig_t x_q [CORDIC_STEPS+1];
  trig_t y_q [CORDIC_STEPS+1];
  ang_t  h_q [CORDIC_STEPS+1];
  logic  flip_q [CORDIC_STEPS+1];
  trig_t sin_q, cos_q;

  ang_t h_full;
  ang_t h_d;
  logic flip_d;

  // halve, widen and fold into plus or minus half pi
  always_comb begin
    h_full = ang_t'($signed(angle_i)) <<< SH;
    h_d    = h_full;
    flip_d = 1'b0;
    if (h_full > HALF_PI_Q30) begin
      h_d    = h_full - PI_Q30;
      flip_d = 1'b1;
    end else if (h_full < -HALF_PI_Q30) begin
      h_d    = h_full + PI_Q30;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= GAIN_Q30;
      y_q[0]    <= '0;
      h_q[0]    <= h_d;
      flip_q[0] <= flip_d;
    end
  end

  // rotation steps
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    trig_t dx, dy;
    ang_t  at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = ang_t'(ATAN_Q30[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (!h_q[i][HW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          h_q[i+1] <= h_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          h_q[i+1] <= h_q[i] + at;
        end
      end
    end
  end

  // undo the pi fold
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= flip_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS];
      cos_q <= flip_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

`ifndef SYNTH
  // folded residual angle stays within half pi
  a_fold_range: assert property (@(posedge clk_i)
    $past(en_i) |-> (h_q[0] <= HALF_PI_Q30) && (h_q[0] >= -HALF_PI_Q30))
    else $error("folded angle out of range");
`endif

endmodule
